// ===== src/pma_pkg.sv =====
// Shared types, constants and helper function for the paged memory allocator.
// Used by pma_ctrl, pma_datapath and paged_memory_allocator; no dependencies.
package pma_pkg;

	localparam int NUM_PAGES   = 32;
	localparam int PAGE_BITS   = 5;
	localparam int CNT_BITS    = 6;
	localparam int ID_BITS     = 8;
	localparam int SIZE_BITS   = 16;
	localparam int NEED_BITS   = 10;
	localparam int PAGE_UNITS  = 100;
	// ceil(2^19 / 100): exact quotient for dividends below 43699
	localparam int RECIP       = 5243;
	localparam int RECIP_SHIFT = 19;

	localparam logic [2:0] CMD_LOAD      = 3'd0;
	localparam logic [2:0] CMD_TERMINATE = 3'd1;
	localparam logic [2:0] CMD_QUERY     = 3'd2;
	localparam logic [2:0] CMD_COMPACT   = 3'd3;
	localparam logic [2:0] CMD_RESET     = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SIZE_ZERO = 3'd1;
	localparam logic [2:0] ST_NO_SPACE  = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic [2:0]           command;
		logic [ID_BITS-1:0]   program_id;
		logic [SIZE_BITS-1:0] program_size;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [PAGE_BITS-1:0] page_index;
		logic [SIZE_BITS-1:0] size_reported;
		logic [CNT_BITS-1:0]  free_pages;
		logic                 last;
	} res_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_NEED,
		OP_FIND,
		OP_APPEND,
		OP_FILL,
		OP_FREE,
		OP_SHIFT,
		OP_QSCAN,
		OP_QEND,
		OP_CP_INIT,
		OP_CP_NEED,
		OP_CP_FILL,
		OP_CP_NEXT,
		OP_RESET_ALL
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       emit;
		logic [2:0] emit_status;
		logic       emit_size;
	} ctl_t;

	typedef struct packed {
		logic scan_end;
		logic hit;
		logic pages_done;
		logic fill_done;
		logic cp_fill_done;
		logic size_zero;
		logic no_space;
		logic prog_full;
		logic all_free;
	} sts_t;

	// Pages needed for a size: ceil(size / PAGE_UNITS) by reciprocal multiply, exact for sizes below 43600.
	function automatic logic [NEED_BITS-1:0] pages_for(input logic [SIZE_BITS-1:0] size);
		logic [SIZE_BITS:0]  x;
		logic [31:0]         prod;
		x    = {1'b0, size} + (SIZE_BITS+1)'(PAGE_UNITS - 1);
		prod = 32'(x) * 32'(RECIP);
		return prod[RECIP_SHIFT +: NEED_BITS];
	endfunction

endpackage

// ===== src/paged_memory_allocator.sv =====
// Top level of the paged memory allocator: joins controller and datapath.
// Depends on pma_pkg, pma_ctrl and pma_datapath.
//
// Usage:
//   Request channel: drive request (command, program_id, program_size) and
//   raise start; the transfer happens at the clock edge where start is high
//   and busy is low. busy stays high until the command has finished.
//   Result channel: each result sits on result for one cycle with
//   result_valid high; the receiver cannot stall, so capture it then.
//   A query of a present program gives one result per owned page in
//   ascending page order, the final one with last set; every other
//   command gives exactly one result, except unknown codes, which give none.
// Command flow (32 pages, 32 program slots):
//   load checks size and space, walks the program table, then scans the
//   pages until its need is met; terminate and query walk the program
//   table then scan all 32 pages; compact walks the table and writes one
//   page per cycle. The page scan and the table walk go one entry per cycle.
// Reset: arst_n frees all pages and empties the program table at once.
// Reset-all command does the same and reports 32 free pages (ST_EMPTY if all were already free).
module paged_memory_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pma_pkg::req_t request,
	output logic          busy,
	output pma_pkg::res_t result,
	output logic          result_valid
);

	pma_pkg::ctl_t ctl;
	pma_pkg::sts_t sts;

	// sequence the command: one datapath operation per cycle
	pma_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	// hold the tables and drive the registered result
	pma_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.ctl          (ctl),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== src/pma_datapath.sv =====
// Datapath of the allocator: page-owner table, program table, counters, result register.
// Depends on pma_pkg; driven by commands from pma_ctrl.
module pma_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  pma_pkg::req_t request,
	input  pma_pkg::ctl_t ctl,
	output pma_pkg::sts_t sts,
	output pma_pkg::res_t result,
	output logic          result_valid
);

	logic                             owner_vld_q [pma_pkg::NUM_PAGES];
	logic [pma_pkg::ID_BITS-1:0]      owner_id_q  [pma_pkg::NUM_PAGES];
	logic [pma_pkg::ID_BITS-1:0]      prog_id_q   [pma_pkg::NUM_PAGES];
	logic [pma_pkg::SIZE_BITS-1:0]    prog_size_q [pma_pkg::NUM_PAGES];
	logic [pma_pkg::CNT_BITS-1:0]     prog_cnt_q;
	logic [pma_pkg::CNT_BITS-1:0]     free_q;
	logic [pma_pkg::CNT_BITS-1:0]     idx_q;
	logic [pma_pkg::CNT_BITS-1:0]     pp_q;
	logic [pma_pkg::NEED_BITS-1:0]    need_q;
	logic [pma_pkg::ID_BITS-1:0]      id_q;
	logic [pma_pkg::SIZE_BITS-1:0]    size_q;
	logic [pma_pkg::SIZE_BITS-1:0]    stored_q;
	logic [pma_pkg::PAGE_BITS-1:0]    at_q;
	logic [pma_pkg::PAGE_BITS-1:0]    pend_q;
	logic                             pend_vld_q;
	pma_pkg::res_t                    res_q;
	logic                             res_valid_q;
	logic [pma_pkg::PAGE_BITS-1:0]    i5;
	logic [pma_pkg::PAGE_BITS-1:0]    p5;
	logic                             own_match;

	assign i5        = idx_q[pma_pkg::PAGE_BITS-1:0];
	assign p5        = pp_q[pma_pkg::PAGE_BITS-1:0];
	assign own_match = owner_vld_q[i5] && (owner_id_q[i5] == id_q);

	assign sts.scan_end     = (idx_q >= prog_cnt_q);
	assign sts.hit          = (prog_id_q[i5] == id_q);
	assign sts.pages_done   = (idx_q == pma_pkg::CNT_BITS'(pma_pkg::NUM_PAGES));
	assign sts.fill_done    = (need_q == '0) || sts.pages_done;
	assign sts.cp_fill_done = (need_q == '0) || (pp_q == pma_pkg::CNT_BITS'(pma_pkg::NUM_PAGES));
	assign sts.size_zero    = (size_q == '0);
	assign sts.no_space     = (need_q > pma_pkg::NEED_BITS'(free_q));
	assign sts.prog_full    = (prog_cnt_q == pma_pkg::CNT_BITS'(pma_pkg::NUM_PAGES));
	assign sts.all_free     = (free_q == pma_pkg::CNT_BITS'(pma_pkg::NUM_PAGES));

	assign result       = res_q;
	assign result_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pma_pkg::NUM_PAGES; i++) begin
				owner_vld_q[i] <= 1'b0;
			end
			prog_cnt_q  <= '0;
			free_q      <= pma_pkg::CNT_BITS'(pma_pkg::NUM_PAGES);
			idx_q       <= '0;
			pp_q        <= '0;
			need_q      <= '0;
			pend_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (ctl.emit) begin
				res_valid_q         <= 1'b1;
				res_q.status        <= ctl.emit_status;
				res_q.page_index    <= '0;
				res_q.size_reported <= ctl.emit_size ? stored_q : '0;
				res_q.free_pages    <= free_q;
				res_q.last          <= 1'b1;
			end
			case (ctl.op)
				pma_pkg::OP_LATCH: begin
					id_q       <= request.program_id;
					size_q     <= request.program_size;
					idx_q      <= '0;
					pend_vld_q <= 1'b0;
				end
				pma_pkg::OP_NEED: begin
					need_q <= pma_pkg::pages_for(size_q);
				end
				pma_pkg::OP_FIND: begin
					if (prog_id_q[i5] == id_q) begin
						at_q     <= i5;
						stored_q <= prog_size_q[i5];
						idx_q    <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				pma_pkg::OP_APPEND: begin
					prog_id_q[prog_cnt_q[pma_pkg::PAGE_BITS-1:0]]   <= id_q;
					prog_size_q[prog_cnt_q[pma_pkg::PAGE_BITS-1:0]] <= size_q;
					prog_cnt_q <= prog_cnt_q + 1'b1;
					idx_q      <= '0;
				end
				pma_pkg::OP_FILL: begin
					if (!owner_vld_q[i5] && need_q != '0) begin
						owner_vld_q[i5] <= 1'b1;
						owner_id_q[i5]  <= id_q;
						need_q          <= need_q - 1'b1;
						free_q          <= free_q - 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				pma_pkg::OP_FREE: begin
					if (own_match) begin
						owner_vld_q[i5] <= 1'b0;
						free_q          <= free_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				pma_pkg::OP_SHIFT: begin
					// close the gap: every entry above the removed one moves down
					for (int i = 0; i < pma_pkg::NUM_PAGES - 1; i++) begin
						if (pma_pkg::PAGE_BITS'(i) >= at_q &&
						    pma_pkg::CNT_BITS'(i + 1) < prog_cnt_q) begin
							prog_id_q[i]   <= prog_id_q[i+1];
							prog_size_q[i] <= prog_size_q[i+1];
						end
					end
					prog_cnt_q <= prog_cnt_q - 1'b1;
				end
				pma_pkg::OP_QSCAN: begin
					if (own_match) begin
						if (pend_vld_q) begin
							res_valid_q         <= 1'b1;
							res_q.status        <= pma_pkg::ST_OK;
							res_q.page_index    <= pend_q;
							res_q.size_reported <= stored_q;
							res_q.free_pages    <= free_q;
							res_q.last          <= 1'b0;
						end
						pend_q     <= i5;
						pend_vld_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				pma_pkg::OP_QEND: begin
					res_valid_q         <= 1'b1;
					res_q.status        <= pma_pkg::ST_OK;
					res_q.page_index    <= pend_vld_q ? pend_q : '0;
					res_q.size_reported <= stored_q;
					res_q.free_pages    <= free_q;
					res_q.last          <= 1'b1;
				end
				pma_pkg::OP_CP_INIT: begin
					for (int i = 0; i < pma_pkg::NUM_PAGES; i++) begin
						owner_vld_q[i] <= 1'b0;
					end
					idx_q <= '0;
					pp_q  <= '0;
				end
				pma_pkg::OP_CP_NEED: begin
					need_q <= pma_pkg::pages_for(prog_size_q[i5]);
				end
				pma_pkg::OP_CP_FILL: begin
					owner_vld_q[p5] <= 1'b1;
					owner_id_q[p5]  <= prog_id_q[i5];
					pp_q            <= pp_q + 1'b1;
					need_q          <= need_q - 1'b1;
				end
				pma_pkg::OP_CP_NEXT: begin
					idx_q <= idx_q + 1'b1;
				end
				pma_pkg::OP_RESET_ALL: begin
					for (int i = 0; i < pma_pkg::NUM_PAGES; i++) begin
						owner_vld_q[i] <= 1'b0;
					end
					prog_cnt_q <= '0;
					free_q     <= pma_pkg::CNT_BITS'(pma_pkg::NUM_PAGES);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/pma_ctrl.sv =====
// Controller state machine of the allocator: sequences datapath operations per command.
// Depends on pma_pkg; steers pma_datapath through ctl_t and reads sts_t.
module pma_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    command,
	input  pma_pkg::sts_t sts,
	output pma_pkg::ctl_t ctl,
	output logic          busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_NEED,
		S_LD_CHK,
		S_LD_FIND,
		S_LD_FILL,
		S_TM_FIND,
		S_TM_FREE,
		S_Q_FIND,
		S_Q_SCAN,
		S_CP_CHK,
		S_CP_NEED,
		S_CP_FILL,
		S_RS_CHK,
		S_RS_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d         = state_q;
		ctl.op          = pma_pkg::OP_NOP;
		ctl.emit        = 1'b0;
		ctl.emit_status = pma_pkg::ST_OK;
		ctl.emit_size   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op = pma_pkg::OP_LATCH;
					case (command)
						pma_pkg::CMD_LOAD:      state_d = S_LD_NEED;
						pma_pkg::CMD_TERMINATE: state_d = S_TM_FIND;
						pma_pkg::CMD_QUERY:     state_d = S_Q_FIND;
						pma_pkg::CMD_COMPACT:   state_d = S_CP_CHK;
						pma_pkg::CMD_RESET:     state_d = S_RS_CHK;
						default:                state_d = S_IDLE;
					endcase
				end
			end
			S_LD_NEED: begin
				ctl.op  = pma_pkg::OP_NEED;
				state_d = S_LD_CHK;
			end
			S_LD_CHK: begin
				if (sts.size_zero) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = pma_pkg::ST_SIZE_ZERO;
					state_d         = S_IDLE;
				end else if (sts.no_space) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = pma_pkg::ST_NO_SPACE;
					state_d         = S_IDLE;
				end else begin
					state_d = S_LD_FIND;
				end
			end
			S_LD_FIND: begin
				if (sts.scan_end) begin
					if (sts.prog_full) begin
						ctl.emit        = 1'b1;
						ctl.emit_status = pma_pkg::ST_DUPLICATE;
						state_d         = S_IDLE;
					end else begin
						ctl.op  = pma_pkg::OP_APPEND;
						state_d = S_LD_FILL;
					end
				end else if (sts.hit) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = pma_pkg::ST_DUPLICATE;
					state_d         = S_IDLE;
				end else begin
					ctl.op = pma_pkg::OP_FIND;
				end
			end
			S_LD_FILL: begin
				if (sts.fill_done) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end else begin
					ctl.op = pma_pkg::OP_FILL;
				end
			end
			S_TM_FIND, S_Q_FIND: begin
				if (sts.scan_end) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = pma_pkg::ST_NOT_FOUND;
					state_d         = S_IDLE;
				end else begin
					ctl.op = pma_pkg::OP_FIND;
					if (sts.hit) begin
						state_d = (state_q == S_TM_FIND) ? S_TM_FREE : S_Q_SCAN;
					end
				end
			end
			S_TM_FREE: begin
				if (sts.pages_done) begin
					ctl.op        = pma_pkg::OP_SHIFT;
					ctl.emit      = 1'b1;
					ctl.emit_size = 1'b1;
					state_d       = S_IDLE;
				end else begin
					ctl.op = pma_pkg::OP_FREE;
				end
			end
			S_Q_SCAN: begin
				if (sts.pages_done) begin
					ctl.op  = pma_pkg::OP_QEND;
					state_d = S_IDLE;
				end else begin
					ctl.op = pma_pkg::OP_QSCAN;
				end
			end
			S_CP_CHK: begin
				if (sts.all_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = pma_pkg::ST_EMPTY;
					state_d         = S_IDLE;
				end else begin
					ctl.op  = pma_pkg::OP_CP_INIT;
					state_d = S_CP_NEED;
				end
			end
			S_CP_NEED: begin
				if (sts.scan_end) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end else begin
					ctl.op  = pma_pkg::OP_CP_NEED;
					state_d = S_CP_FILL;
				end
			end
			S_CP_FILL: begin
				if (sts.cp_fill_done) begin
					ctl.op  = pma_pkg::OP_CP_NEXT;
					state_d = S_CP_NEED;
				end else begin
					ctl.op = pma_pkg::OP_CP_FILL;
				end
			end
			S_RS_CHK: begin
				if (sts.all_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = pma_pkg::ST_EMPTY;
					state_d         = S_IDLE;
				end else begin
					ctl.op  = pma_pkg::OP_RESET_ALL;
					state_d = S_RS_EMIT;
				end
			end
			S_RS_EMIT: begin
				ctl.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sim/tb_paged_memory_allocator.sv =====
// Testbench for paged_memory_allocator: drives commands, predicts results, checks them.
// Depends on pma_pkg and the RTL; self-contained otherwise.
module tb_paged_memory_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import pma_pkg::*;

	// Tracks allocator state and holds the results still owed by the block.
	class alloc_scoreboard;
		bit          page_used [NUM_PAGES];
		bit [7:0]    page_id [NUM_PAGES];
		bit [7:0]    prog_ids [$];
		bit [15:0]   prog_sizes [$];
		int unsigned free_cnt;
		res_t        pending [$];
		int          errors;

		function void clear();
			foreach (page_used[p]) begin
				page_used[p] = 0;
				page_id[p] = 0;
			end
			prog_ids.delete();
			prog_sizes.delete();
			free_cnt = NUM_PAGES;
		endfunction

		function int unsigned pages_needed(bit [15:0] sz);
			return (int'(sz) + PAGE_UNITS - 1) / PAGE_UNITS;
		endfunction

		function int locate(bit [7:0] id);
			foreach (prog_ids[i])
				if (prog_ids[i] == id)
					return i;
			return -1;
		endfunction

		function void push(bit [2:0] st, bit [4:0] pg, bit [15:0] sz, bit lst);
			res_t r;
			r.status = st;
			r.page_index = pg;
			r.size_reported = sz;
			r.free_pages = free_cnt[5:0];
			r.last = lst;
			pending.push_back(r);
		endfunction

		// Apply one accepted command and queue its results.
		function void note_request(req_t q);
			int at;
			int unsigned need;
			int unsigned p;
			int n;
			case (q.command)
				CMD_LOAD: begin
					need = pages_needed(q.program_size);
					if (q.program_size == 0)
						push(ST_SIZE_ZERO, 0, 0, 1);
					else if (need > free_cnt)
						push(ST_NO_SPACE, 0, 0, 1);
					else if (locate(q.program_id) >= 0 || prog_ids.size() >= NUM_PAGES)
						push(ST_DUPLICATE, 0, 0, 1);
					else begin
						prog_ids.push_back(q.program_id);
						prog_sizes.push_back(q.program_size);
						for (p = 0; p < NUM_PAGES && need > 0; p++)
							if (!page_used[p]) begin
								page_used[p] = 1;
								page_id[p] = q.program_id;
								need--;
								free_cnt--;
							end
						push(ST_OK, 0, 0, 1);
					end
				end
				CMD_TERMINATE: begin
					at = locate(q.program_id);
					if (at < 0)
						push(ST_NOT_FOUND, 0, 0, 1);
					else begin
						for (p = 0; p < NUM_PAGES; p++)
							if (page_used[p] && page_id[p] == q.program_id) begin
								page_used[p] = 0;
								page_id[p] = 0;
								free_cnt++;
							end
						push(ST_OK, 0, prog_sizes[at], 1);
						prog_ids.delete(at);
						prog_sizes.delete(at);
					end
				end
				CMD_QUERY: begin
					at = locate(q.program_id);
					n = 0;
					if (at < 0)
						push(ST_NOT_FOUND, 0, 0, 1);
					else begin
						for (p = 0; p < NUM_PAGES; p++)
							if (page_used[p] && page_id[p] == q.program_id) begin
								push(ST_OK, p[4:0], prog_sizes[at], 0);
								n++;
							end
						if (n == 0)
							push(ST_OK, 0, prog_sizes[at], 1);
						else
							pending[pending.size()-1].last = 1;
					end
				end
				CMD_COMPACT: begin
					if (free_cnt >= NUM_PAGES)
						push(ST_EMPTY, 0, 0, 1);
					else begin
						foreach (page_used[k]) begin
							page_used[k] = 0;
							page_id[k] = 0;
						end
						p = 0;
						foreach (prog_ids[i]) begin
							need = pages_needed(prog_sizes[i]);
							while (need > 0 && p < NUM_PAGES) begin
								page_used[p] = 1;
								page_id[p] = prog_ids[i];
								p++;
								need--;
							end
						end
						push(ST_OK, 0, 0, 1);
					end
				end
				CMD_RESET: begin
					if (free_cnt >= NUM_PAGES)
						push(ST_EMPTY, 0, 0, 1);
					else begin
						clear();
						push(ST_OK, 0, 0, 1);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", 0, got);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", want, got);
			if (got.page_index !== want.page_index)
				report_mismatch("page_index", want, got);
			if (got.size_reported !== want.size_reported)
				report_mismatch("size_reported", want, got);
			if (got.free_pages !== want.free_pages)
				report_mismatch("free_pages", want, got);
			if (got.last !== want.last)
				report_mismatch("last", want, got);
		endfunction

		function void report_mismatch(string what, res_t want, res_t got);
			errors++;
			$display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_t request;
	logic busy;
	res_t result;
	logic result_valid;

	alloc_scoreboard board;
	int idle_pct;
	int stall_cycles;
	bit [7:0] live_ids [$];

	paged_memory_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .result(result), .result_valid(result_valid)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Check every result on the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_result(result);
	end

	// Watchdog: count cycles with no transfer in either direction.
	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Present one command and hold it until the block takes the transfer.
	// start is left high; the next send or drain drives it in the same step.
	task automatic send(bit [2:0] cmd, bit [7:0] id, bit [15:0] sz);
		req_t q;
		q.command = cmd;
		q.program_id = id;
		q.program_size = sz;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		request <= q;
		do
			@(posedge clk);
		while (busy);
		board.note_request(q);
	endtask

	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// Mostly well-formed traffic: loads of small programs, queries and
	// terminates of ids that are live, occasional compact and noise.
	task automatic random_phase(int count);
		int r;
		bit [7:0] id;
		bit [15:0] sz;
		repeat (count) begin
			r = $urandom_range(99);
			id = live_ids.size() ? live_ids[$urandom_range(live_ids.size()-1)]
			                     : 8'($urandom);
			if (r < 35) begin
				id = ($urandom_range(3) == 0) ? id : 8'($urandom);
				case ($urandom_range(9))
					0: sz = 16'($urandom);
					1: sz = 0;
					default: sz = 16'($urandom_range(1, 600));
				endcase
				send(CMD_LOAD, id, sz);
				live_ids.push_back(id);
			end else if (r < 55)
				send(CMD_QUERY, ($urandom_range(5) == 0) ? 8'($urandom) : id, 16'($urandom));
			else if (r < 75)
				send(CMD_TERMINATE, ($urandom_range(5) == 0) ? 8'($urandom) : id,
				     16'($urandom));
			else if (r < 85)
				send(CMD_COMPACT, 8'($urandom), 16'($urandom));
			else if (r < 89)
				send(CMD_RESET, 8'($urandom), 16'($urandom));
			else if (r < 92)
				send(3'($urandom_range(5, 7)), 8'($urandom), 16'($urandom));
			else
				send(CMD_QUERY, id, 0);
			if (live_ids.size() > 40)
				live_ids.delete(0);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		stall_cycles = 0;
		start = 0;
		request = '0;
		arst_n = 0;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty-memory cases, every status, field extremes.
		send(CMD_COMPACT, 8'h00, 16'h0000);
		send(CMD_RESET, 8'hff, 16'hffff);
		send(CMD_QUERY, 8'h00, 16'h0000);
		send(CMD_TERMINATE, 8'hff, 16'h0000);
		send(CMD_LOAD, 8'h01, 16'h0000);
		send(CMD_LOAD, 8'h01, 16'hffff);
		send(CMD_LOAD, 8'h01, 16'd100);
		send(CMD_LOAD, 8'h01, 16'd5);
		send(CMD_LOAD, 8'hff, 16'd101);
		send(CMD_LOAD, 8'h00, 16'd2500);
		send(CMD_LOAD, 8'haa, 16'd3200);
		send(CMD_QUERY, 8'h00, 16'hffff);
		send(CMD_TERMINATE, 8'hff, 16'h0000);
		send(3'd7, 8'h55, 16'h5555);
		send(CMD_COMPACT, 8'h00, 16'h0000);
		send(CMD_QUERY, 8'h00, 16'h0000);
		send(CMD_QUERY, 8'h01, 16'h0000);
		send(CMD_RESET, 8'h00, 16'h0000);
		send(CMD_LOAD, 8'h55, 16'd3200);
		send(CMD_QUERY, 8'h55, 16'h0000);
		send(CMD_TERMINATE, 8'h55, 16'h0000);
		send(3'd5, 8'haa, 16'haaaa);
		send(3'd6, 8'h00, 16'h0000);
		// Hold off until every expected result has come.
		drain();

		idle_pct = 32;
		random_phase(150);
		drain();
		idle_pct = 52;
		random_phase(140);
		idle_pct = 0;
		random_phase(140);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
